@@ rtl/core/la32r_pkg.sv @@
package la32r_pkg;

   localparam int RegCountDefault = 32;
   localparam int XLEN = 32;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_BREAK   = 2'd2,
      ST_HOST    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      LK_B  = 3'd0,
      LK_H  = 3'd1,
      LK_W  = 3'd2,
      LK_BU = 3'd3,
      LK_HU = 3'd4
   } load_kind_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_EXEC,
      FSM_DIV,
      FSM_OUT
   } fsm_type;

   typedef struct packed {
      logic [0:0]  cmd;
      logic [31:0] instr;
      logic [31:0] pc;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [0:0]  mem_read;
      logic [0:0]  mem_write;
      logic [31:0] mem_addr;
      logic [1:0]  mem_size;
      logic [31:0] store_data;
      logic [1:0]  status;
      logic [31:0] halt_value;
   } rsp_type;

   typedef struct packed {
      logic        start;
      logic        is_signed;
      logic        want_rem;
      logic [31:0] a;
      logic [31:0] b;
   } div_cmd_type;

   localparam logic [5:0]  OP6_B    = 6'h14;
   localparam logic [5:0]  OP6_BL   = 6'h15;
   localparam logic [5:0]  OP6_JIRL = 6'h13;
   localparam logic [5:0]  OP6_BEQ  = 6'h16;
   localparam logic [5:0]  OP6_BNE  = 6'h17;
   localparam logic [5:0]  OP6_BLT  = 6'h18;
   localparam logic [5:0]  OP6_BGE  = 6'h19;
   localparam logic [5:0]  OP6_BLTU = 6'h1a;
   localparam logic [5:0]  OP6_BGEU = 6'h1b;
   localparam logic [6:0]  OP7_LU12I = 7'h0a;
   localparam logic [6:0]  OP7_PCADD = 7'h0e;
   localparam logic [9:0]  OP10_SLTI  = 10'h08;
   localparam logic [9:0]  OP10_SLTUI = 10'h09;
   localparam logic [9:0]  OP10_ADDI  = 10'h0a;
   localparam logic [9:0]  OP10_ANDI  = 10'h0d;
   localparam logic [9:0]  OP10_ORI   = 10'h0e;
   localparam logic [9:0]  OP10_XORI  = 10'h0f;
   localparam logic [9:0]  OP10_LDB   = 10'ha0;
   localparam logic [9:0]  OP10_LDH   = 10'ha1;
   localparam logic [9:0]  OP10_LDW   = 10'ha2;
   localparam logic [9:0]  OP10_LDBU  = 10'ha8;
   localparam logic [9:0]  OP10_LDHU  = 10'ha9;
   localparam logic [9:0]  OP10_STB   = 10'ha4;
   localparam logic [9:0]  OP10_STH   = 10'ha5;
   localparam logic [9:0]  OP10_STW   = 10'ha6;
   localparam logic [16:0] OP17_ADD   = 17'h20;
   localparam logic [16:0] OP17_SUB   = 17'h22;
   localparam logic [16:0] OP17_SLT   = 17'h24;
   localparam logic [16:0] OP17_SLTU  = 17'h25;
   localparam logic [16:0] OP17_NOR   = 17'h28;
   localparam logic [16:0] OP17_AND   = 17'h29;
   localparam logic [16:0] OP17_OR    = 17'h2a;
   localparam logic [16:0] OP17_XOR   = 17'h2b;
   localparam logic [16:0] OP17_SLL   = 17'h2e;
   localparam logic [16:0] OP17_SRL   = 17'h2f;
   localparam logic [16:0] OP17_SRA   = 17'h30;
   localparam logic [16:0] OP17_MUL   = 17'h38;
   localparam logic [16:0] OP17_MULH  = 17'h39;
   localparam logic [16:0] OP17_MULHU = 17'h3a;
   localparam logic [16:0] OP17_DIV   = 17'h40;
   localparam logic [16:0] OP17_MOD   = 17'h41;
   localparam logic [16:0] OP17_DIVU  = 17'h42;
   localparam logic [16:0] OP17_MODU  = 17'h43;
   localparam logic [16:0] OP17_SLLI  = 17'h81;
   localparam logic [16:0] OP17_SRLI  = 17'h89;
   localparam logic [16:0] OP17_SRAI  = 17'h91;
   localparam logic [16:0] OP17_BREAK = 17'h54;
   localparam logic [16:0] OP17_SYSC  = 17'h56;
   localparam logic [31:0] INSTR_ERTN = 32'h06483800;
   localparam logic [7:0]  OP8_CSR    = 8'h04;

endpackage

@@ rtl/core/la32r_if.sv @@
interface la32r_req_if import la32r_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface la32r_rsp_if import la32r_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/la32r_integer_execute_unit_core.sv @@
// One item at a time. Execute item: on accept rj, rk, rd and r4 are read from
// the register file (three copies written together; rd and r4 share one),
// the execute state computes and writes back, the result register then holds
// the transfer until taken; mul/mulh/mulhu add a second execute pass for the
// registered product, div/mod wait in the divide state for the serial divider.
// Load return items write the loaded value in the execute state. No clearing
// pass: register valid bits reset the file to zero at once.
module la32r_integer_execute_unit_core import la32r_pkg::*; #(
   parameter int REG_COUNT = RegCountDefault
) (
   input logic clock,
   input logic reset,
   la32r_req_if.sink req,
   la32r_rsp_if.source rsp
);
   localparam int AW = $clog2(REG_COUNT);

   logic [31:0] mem_a [REG_COUNT];
   logic [31:0] mem_b [REG_COUNT];
   logic [31:0] mem_d [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff, vld_in;
   logic [31:0] ra_ff, rb_ff, rd_ff, r4_ff;
   logic [AW-1:0] ia_ff, ib_ff, id_ff;

   fsm_type state_ff, state_in;
   req_type item_ff;
   rsp_type out_ff, out_in;
   logic load_pending_ff, load_pending_in;
   logic [4:0] load_dest_ff, load_dest_in;
   load_kind_type load_kind_ff, load_kind_in;
   logic [63:0] prod_ff;
   logic mul_wait_ff, mul_wait_in;

   logic        wen;
   logic [4:0]  waddr;
   logic [31:0] wdata;
   logic accept;
   div_cmd_type dcmd;
   logic dv_done;
   logic [31:0] dv_result;

   assign accept = req.valid && req.ready;
   assign req.ready = (state_ff == FSM_IDLE);
   assign rsp.valid = (state_ff == FSM_OUT);
   assign rsp.data = out_ff;

   la32r_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .done(dv_done),
      .result(dv_result));

   always_ff @(posedge clock) begin
      if (accept) begin
         ra_ff <= mem_a[req.data.instr[5+AW-1:5]];
         rb_ff <= mem_b[req.data.instr[10+AW-1:10]];
         rd_ff <= mem_d[req.data.instr[AW-1:0]];
         r4_ff <= mem_d[AW'(4)];
         ia_ff <= req.data.instr[5+AW-1:5];
         ib_ff <= req.data.instr[10+AW-1:10];
         id_ff <= req.data.instr[AW-1:0];
         item_ff <= req.data;
      end
      if (wen) begin
         mem_a[waddr[AW-1:0]] <= wdata;
         mem_b[waddr[AW-1:0]] <= wdata;
         mem_d[waddr[AW-1:0]] <= wdata;
      end
   end

   // operand values with valid-bit masking (register 0 never valid)
   logic [31:0] a, b, d, r4v;
   assign a = vld_ff[ia_ff] ? ra_ff : '0;
   assign b = vld_ff[ib_ff] ? rb_ff : '0;
   assign d = vld_ff[id_ff] ? rd_ff : '0;
   assign r4v = vld_ff[AW'(4)] ? r4_ff : '0;

   logic [31:0] instr, pc, snpc, si12, ui12, off16, ldv;
   logic [16:0] op17;
   logic [9:0]  op10;
   logic [4:0]  rd, rk;
   logic is_mul, is_div;
   logic signed [32:0] ma, mb;

   always_comb begin
      instr = item_ff.instr; pc = item_ff.pc;
      rd = instr[4:0]; rk = instr[14:10];
      op17 = instr[31:15]; op10 = instr[31:22];
      snpc = pc + 32'd4;
      si12 = {{20{instr[21]}}, instr[21:10]};
      ui12 = {20'd0, instr[21:10]};
      off16 = {{14{instr[25]}}, instr[25:10], 2'b00};
      is_mul = (op17 == OP17_MUL) || (op17 == OP17_MULH) || (op17 == OP17_MULHU);
      is_div = (op17 == OP17_DIV) || (op17 == OP17_MOD) || (op17 == OP17_DIVU)
         || (op17 == OP17_MODU);
      ma = {(op17 != OP17_MULHU) && a[31], a};
      mb = {(op17 != OP17_MULHU) && b[31], b};
      unique case (load_kind_ff)
         LK_B:    ldv = {{24{item_ff.load_data[7]}}, item_ff.load_data[7:0]};
         LK_H:    ldv = {{16{item_ff.load_data[15]}}, item_ff.load_data[15:0]};
         LK_BU:   ldv = {24'd0, item_ff.load_data[7:0]};
         LK_HU:   ldv = {16'd0, item_ff.load_data[15:0]};
         default: ldv = item_ff.load_data;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= 64'(ma * mb);
   end

   // execute and writeback
   always_comb begin
      logic t;
      logic [31:0] v;
      logic w;
      out_in = out_ff;
      wen = 1'b0; waddr = rd; wdata = '0;
      load_pending_in = load_pending_ff; load_dest_in = load_dest_ff;
      load_kind_in = load_kind_ff;
      mul_wait_in = 1'b0;
      dcmd = '{start: 1'b0, is_signed: (op17 == OP17_DIV) || (op17 == OP17_MOD),
               want_rem: (op17 == OP17_MOD) || (op17 == OP17_MODU), a: a, b: b};
      t = 1'b0; v = '0; w = 1'b0;
      if (state_ff == FSM_EXEC && item_ff.cmd == 1'b1) begin
         out_in = '0;
         if (load_pending_ff) begin
            wen = (load_dest_ff != 5'd0); waddr = load_dest_ff; wdata = ldv;
            load_pending_in = 1'b0;
         end
      end else if (state_ff == FSM_EXEC && !mul_wait_ff) begin
         out_in = '0;
         out_in.next_pc = snpc;
         if (instr[31:26] == OP6_B || instr[31:26] == OP6_BL) begin
            out_in.next_pc = pc + {{4{instr[9]}}, instr[9:0], instr[25:10], 2'b00};
            if (instr[31:26] == OP6_BL) begin
               w = 1'b1; waddr = 5'd1; v = snpc;
            end
         end else if (instr[31:26] == OP6_JIRL) begin
            out_in.next_pc = a + off16; w = 1'b1; v = snpc;
         end else if (instr[31:26] >= OP6_BEQ && instr[31:26] <= OP6_BGEU) begin
            case (instr[31:26])
               OP6_BEQ:  t = a == d;
               OP6_BNE:  t = a != d;
               OP6_BLT:  t = $signed(a) < $signed(d);
               OP6_BGE:  t = !($signed(a) < $signed(d));
               OP6_BLTU: t = a < d;
               default:  t = a >= d;
            endcase
            out_in.next_pc = pc + (t ? off16 : 32'd4);
         end else if (instr[31:25] == OP7_LU12I || instr[31:25] == OP7_PCADD) begin
            w = 1'b1;
            v = (instr[31:25] == OP7_PCADD) ? pc + {instr[24:5], 12'd0}
                                            : {instr[24:5], 12'd0};
         end else if (op10 == OP10_SLTI) begin
            w = 1'b1; v = {31'd0, $signed(a) < $signed(si12)};
         end else if (op10 == OP10_SLTUI) begin
            w = 1'b1; v = {31'd0, a < si12};
         end else if (op10 == OP10_ADDI) begin
            w = 1'b1; v = a + si12;
         end else if (op10 == OP10_ANDI) begin
            w = 1'b1; v = a & ui12;
         end else if (op10 == OP10_ORI) begin
            w = 1'b1; v = a | ui12;
         end else if (op10 == OP10_XORI) begin
            w = 1'b1; v = a ^ ui12;
         end else if (op10 == OP10_LDB || op10 == OP10_LDH || op10 == OP10_LDW
                      || op10 == OP10_LDBU || op10 == OP10_LDHU) begin
            out_in.mem_read = 1'b1;
            out_in.mem_addr = a + si12;
            out_in.mem_size = (op10 == OP10_LDH || op10 == OP10_LDHU) ? 2'd1 :
                              (op10 == OP10_LDW) ? 2'd2 : 2'd0;
            load_pending_in = 1'b1; load_dest_in = rd;
            case (op10)
               OP10_LDB:  load_kind_in = LK_B;
               OP10_LDH:  load_kind_in = LK_H;
               OP10_LDW:  load_kind_in = LK_W;
               OP10_LDBU: load_kind_in = LK_BU;
               default:   load_kind_in = LK_HU;
            endcase
         end else if (op10 == OP10_STB || op10 == OP10_STH || op10 == OP10_STW) begin
            out_in.mem_write = 1'b1;
            out_in.mem_addr = a + si12;
            out_in.mem_size = 2'(op10 - OP10_STB);
            out_in.store_data = d;
         end else begin
            w = 1'b1;
            case (op17)
               OP17_ADD:  v = a + b;
               OP17_SUB:  v = a - b;
               OP17_SLT:  v = {31'd0, $signed(a) < $signed(b)};
               OP17_SLTU: v = {31'd0, a < b};
               OP17_NOR:  v = ~(a | b);
               OP17_AND:  v = a & b;
               OP17_OR:   v = a | b;
               OP17_XOR:  v = a ^ b;
               OP17_SLL:  v = a << b[4:0];
               OP17_SRL:  v = a >> b[4:0];
               OP17_SRA:  v = 32'($signed(a) >>> b[4:0]);
               OP17_SLLI: v = a << rk;
               OP17_SRLI: v = a >> rk;
               OP17_SRAI: v = 32'($signed(a) >>> rk);
               OP17_MUL, OP17_MULH, OP17_MULHU: begin
                  w = 1'b0; mul_wait_in = 1'b1;
               end
               OP17_DIV, OP17_MOD, OP17_DIVU, OP17_MODU: begin
                  w = 1'b0; dcmd.start = 1'b1;
               end
               OP17_BREAK: begin
                  w = 1'b0; out_in.status = ST_BREAK; out_in.halt_value = r4v;
                  out_in.next_pc = pc;
               end
               OP17_SYSC: begin
                  w = 1'b0; out_in.status = ST_HOST;
               end
               default: begin
                  w = 1'b0;
                  if (instr == INSTR_ERTN || instr[31:24] == OP8_CSR) begin
                     out_in.status = ST_HOST;
                  end else begin
                     out_in.status = ST_INVALID; out_in.next_pc = pc;
                  end
               end
            endcase
         end
         wen = w && (waddr != 5'd0); wdata = v;
      end else if (state_ff == FSM_EXEC) begin
         // product registered last cycle
         wdata = (op17 == OP17_MUL) ? prod_ff[31:0] : prod_ff[63:32];
         wen = (rd != 5'd0);
      end else if (state_ff == FSM_DIV && dv_done) begin
         wdata = dv_result;
         wen = (rd != 5'd0);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: if (accept) state_in = FSM_EXEC;
         FSM_EXEC: begin
            if (item_ff.cmd == 1'b0 && !mul_wait_ff && is_div) state_in = FSM_DIV;
            else if (item_ff.cmd == 1'b0 && !mul_wait_ff && is_mul
                     && op10 != OP10_LDB) state_in = FSM_EXEC;
            else state_in = FSM_OUT;
         end
         FSM_DIV: if (dv_done) state_in = FSM_OUT;
         FSM_OUT: if (rsp.ready) state_in = FSM_IDLE;
         default: state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      vld_in = vld_ff;
      if (wen) vld_in[waddr[AW-1:0]] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
         vld_ff <= '0;
         load_pending_ff <= 1'b0;
         load_dest_ff <= '0;
         load_kind_ff <= LK_B;
         mul_wait_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
         load_pending_ff <= load_pending_in;
         load_dest_ff <= load_dest_in;
         load_kind_ff <= load_kind_in;
         mul_wait_ff <= mul_wait_in;
      end
      out_ff <= out_in;
   end

   assert property (@(posedge clock) disable iff (reset) !vld_ff[0])
      else $error("register 0 marked written");
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("result changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      dv_done |-> state_ff == FSM_DIV)
      else $error("divider finished outside divide wait");
   assert property (@(posedge clock) disable iff (reset)
      accept |=> !rsp.valid)
      else $error("result raised in same cycle as operand read");
endmodule

@@ rtl/core/la32r_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module la32r_div import la32r_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output logic        done,
   output logic [31:0] result
);
   logic [31:0] quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, rsel_ff, rsel_in;
   logic        zero_ff, zero_in, done_ff, done_in;
   logic [31:0] a0_ff, a0_in;
   logic [32:0] trial;
   logic [31:0] ma, mb, qf, rf;

   always_comb begin
      ma = (cmd.is_signed && cmd.a[31]) ? (32'd0 - cmd.a) : cmd.a;
      mb = (cmd.is_signed && cmd.b[31]) ? (32'd0 - cmd.b) : cmd.b;
      trial = {rem_ff, quo_ff[31]} - {1'b0, dsr_ff};
      quo_in = quo_ff; rem_in = rem_ff; dsr_in = dsr_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_q_in = neg_q_ff; neg_r_in = neg_r_ff; rsel_in = rsel_ff;
      zero_in = zero_ff; a0_in = a0_ff; done_in = 1'b0;
      if (cmd.start) begin
         quo_in = ma; rem_in = '0; dsr_in = mb; cnt_in = 6'd32; busy_in = 1'b1;
         neg_q_in = cmd.is_signed && (cmd.a[31] != cmd.b[31]);
         neg_r_in = cmd.is_signed && cmd.a[31];
         rsel_in = cmd.want_rem; zero_in = (cmd.b == '0); a0_in = cmd.a;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; dsr_ff <= dsr_in; cnt_ff <= cnt_in;
      neg_q_ff <= neg_q_in; neg_r_ff <= neg_r_in; rsel_ff <= rsel_in;
      zero_ff <= zero_in; a0_ff <= a0_in;
   end

   always_comb begin
      qf = neg_q_ff ? (32'd0 - quo_ff) : quo_ff;
      rf = neg_r_ff ? (32'd0 - rem_ff) : rem_ff;
      if (zero_ff) result = rsel_ff ? a0_ff : '1;
      else result = rsel_ff ? rf : qf;
   end
   assign done = done_ff;
endmodule
